FILE: rtl/core/sort_pkg.sv
// Package for the single outstanding request tracker: types, codes and sizes.
`default_nettype none

package sort_pkg;

	localparam int TAG_BITS = 16;
	localparam int CALL_TAG_W = 16;
	localparam int CMP_W = (TAG_BITS > CALL_TAG_W) ? TAG_BITS : CALL_TAG_W;
	localparam int TICK_W = 16;

	typedef logic [TAG_BITS-1:0]   tag_t;
	typedef logic [CALL_TAG_W-1:0] ctag_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [TICK_W-1:0]     ticks_t;

	localparam ticks_t TIMEOUT_RST = ticks_t'(100);

	// Command codes
	localparam logic [2:0] CMD_CALL     = 3'd0;
	localparam logic [2:0] CMD_POST     = 3'd1;
	localparam logic [2:0] CMD_REPLY    = 3'd2;
	localparam logic [2:0] CMD_TICK     = 3'd3;
	localparam logic [2:0] CMD_CHAN_RST = 3'd4;

	// Outcome codes
	localparam logic [1:0] OC_OK      = 2'd0;
	localparam logic [1:0] OC_TIMEOUT = 2'd1;
	localparam logic [1:0] OC_BAD     = 2'd2;
	localparam logic [1:0] OC_NAK     = 2'd3;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [7:0]       req_command;
		logic [7:0]       req_node;
		logic             fifo_room;
		logic [15:0]      reply_tag;
		logic [7:0]       reply_command;
		logic [7:0]       reply_node;
		logic [1:0]       reply_outcome;
		logic [7:0]       reply_reason;
	} in_item_t;

	typedef struct packed {
		logic             accepted;
		logic             completed;
		logic [1:0]       outcome;
		ctag_t            call_tag;
		logic             busy_res;
		logic [7:0]       nak_reason;
	} res_t;

	// Handshake status between the stages
	typedef struct packed {
		logic advance;
		logic fire;
	} flow_t;

endpackage

`default_nettype wire

FILE: rtl/core/sort_in_stage.sv
// Input register stage: holds one accepted transaction for the tracker.
`default_nettype none

module sort_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sort_pkg::in_item_t in_item,
	input  wire logic              advance,
	output sort_pkg::flow_t        flow,
	output sort_pkg::in_item_t     item_s1
);

	logic valid_s1;

	assign in_ready = !valid_s1 || advance;
	assign flow.advance = advance;
	assign flow.fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sort_engine.sv
// Tracker state and per-transaction update logic.
`default_nettype none

module sort_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire sort_pkg::ticks_t   cfg_timeout,
	input  wire sort_pkg::flow_t    flow,
	input  wire sort_pkg::in_item_t item_s1,
	output sort_pkg::res_t          res
);

	sort_pkg::ticks_t timeout_q;
	sort_pkg::tag_t   next_tag_q, next_tag_d, tag_inc;
	logic             in_flight_q, in_flight_d;
	logic             waiting_q, waiting_d;
	sort_pkg::tag_t   pend_tag_q, pend_tag_d;
	logic [7:0]       pend_cmd_q, pend_cmd_d;
	logic [7:0]       pend_node_q, pend_node_d;
	sort_pkg::ticks_t ticks_q, ticks_d;
	logic [7:0]       reason_q, reason_d;
	logic             mismatch;

	assign tag_inc = (next_tag_q + sort_pkg::tag_t'(1) == '0) ? sort_pkg::tag_t'(1)
	                 : next_tag_q + sort_pkg::tag_t'(1);

	assign mismatch = (sort_pkg::cmp_t'(item_s1.reply_tag) != sort_pkg::cmp_t'(pend_tag_q))
	                  || (item_s1.reply_command != pend_cmd_q)
	                  || (item_s1.reply_node != pend_node_q);

	always_comb begin
		next_tag_d  = next_tag_q;
		in_flight_d = in_flight_q;
		waiting_d   = waiting_q;
		pend_tag_d  = pend_tag_q;
		pend_cmd_d  = pend_cmd_q;
		pend_node_d = pend_node_q;
		ticks_d     = ticks_q;
		reason_d    = reason_q;
		res.accepted  = 1'b0;
		res.completed = 1'b0;
		res.outcome   = sort_pkg::OC_OK;
		res.call_tag  = '0;
		case (item_s1.cmd)
			sort_pkg::CMD_CALL: begin
				next_tag_d   = tag_inc;
				res.call_tag = sort_pkg::ctag_t'(next_tag_q);
				if (in_flight_q || !item_s1.fifo_room) begin
					res.completed = 1'b1;
					res.outcome   = sort_pkg::OC_TIMEOUT;
				end else begin
					res.accepted = 1'b1;
					in_flight_d  = 1'b1;
					waiting_d    = 1'b1;
					pend_tag_d   = next_tag_q;
					pend_cmd_d   = item_s1.req_command;
					pend_node_d  = item_s1.req_node;
					ticks_d      = timeout_q;
				end
			end
			sort_pkg::CMD_POST: begin
				res.accepted = item_s1.fifo_room;
			end
			sort_pkg::CMD_REPLY: begin
				in_flight_d = 1'b0;
				if (waiting_q) begin
					waiting_d     = 1'b0;
					res.completed = 1'b1;
					if (mismatch) begin
						res.outcome = sort_pkg::OC_BAD;
					end else begin
						res.outcome = item_s1.reply_outcome;
						reason_d = (item_s1.reply_outcome == sort_pkg::OC_NAK) ?
						           item_s1.reply_reason : 8'd0;
					end
				end
			end
			sort_pkg::CMD_TICK: begin
				if (waiting_q) begin
					if (ticks_q <= sort_pkg::ticks_t'(1)) begin
						ticks_d       = '0;
						waiting_d     = 1'b0;
						in_flight_d   = 1'b0;
						res.completed = 1'b1;
						res.outcome   = sort_pkg::OC_TIMEOUT;
					end else begin
						ticks_d = ticks_q - sort_pkg::ticks_t'(1);
					end
				end
			end
			sort_pkg::CMD_CHAN_RST: begin
				in_flight_d = 1'b0;
			end
			default: begin
			end
		endcase
		res.busy_res   = in_flight_d;
		res.nak_reason = reason_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sort_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_timeout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_tag_q  <= sort_pkg::tag_t'(1);
			in_flight_q <= 1'b0;
			waiting_q   <= 1'b0;
			pend_tag_q  <= '0;
			pend_cmd_q  <= '0;
			pend_node_q <= '0;
			ticks_q     <= '0;
			reason_q    <= '0;
		end else if (flow.fire) begin
			next_tag_q  <= next_tag_d;
			in_flight_q <= in_flight_d;
			waiting_q   <= waiting_d;
			pend_tag_q  <= pend_tag_d;
			pend_cmd_q  <= pend_cmd_d;
			pend_node_q <= pend_node_d;
			ticks_q     <= ticks_d;
			reason_q    <= reason_d;
		end
	end

`ifndef SYNTH
	a_flight_waits: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q |-> waiting_q) else $error("in-flight call not waiting");
	a_tag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_tag_q != '0) else $error("tag counter reached zero");
	a_acc_xor_done: assert property (@(posedge clk) disable iff (!arst_n)
		flow.fire |-> !(res.accepted && res.completed))
		else $error("transaction both accepted and completed");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!flow.fire |=> $stable(next_tag_q) && $stable(waiting_q))
		else $error("state moved without a transaction");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sort_out_stage.sv
// Result register stage towards the master side.
`default_nettype none

module sort_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sort_pkg::flow_t flow,
	input  wire sort_pkg::res_t  res,
	output logic                 advance,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sort_pkg::res_t       res_q
);

	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (flow.fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.fire) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/single_outstanding_request_tracker.sv
// Top level of the single outstanding request tracker.
//
//  channel   direction  signals                           contents
//  s_axis    in         s_tvalid s_tready s_tdata s_tuser  one event per transaction
//  m_axis    out        m_tvalid m_tready m_tdata          one result per event
//  cfg       in         cfg_valid cfg_ready cfg_data       timeout_ticks register
//
// One transaction per cycle sustained while m_tready is high; each passes the input
// register, then the result register. The state update sits between the two registers.
// Reset clears all tracker state; timeout_ticks returns to 100.
// A stalled m_tready holds the result; an empty input register still takes one
// transaction, and once it is full s_tready falls. cfg_ready is always high.
`default_nettype none

module single_outstanding_request_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_command[7:0] req_node[15:8] fifo_room[16] reply_tag[32:17]
	// reply_command[40:33] reply_node[48:41] reply_outcome[50:49] reply_reason[58:51]
	input  wire logic [63:0] s_tdata,
	// cmd[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// accepted[0] completed[1] outcome[3:2] call_tag[19:4] busy_res[20] nak_reason[28:21]
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	sort_pkg::in_item_t in_item, item_s1;
	sort_pkg::flow_t    flow;
	sort_pkg::res_t     res, res_q;
	logic               advance;

	assign cfg_ready = 1'b1;

	assign in_item.cmd           = s_tuser;
	assign in_item.req_command   = s_tdata[7:0];
	assign in_item.req_node      = s_tdata[15:8];
	assign in_item.fifo_room     = s_tdata[16];
	assign in_item.reply_tag     = s_tdata[32:17];
	assign in_item.reply_command = s_tdata[40:33];
	assign in_item.reply_node    = s_tdata[48:41];
	assign in_item.reply_outcome = s_tdata[50:49];
	assign in_item.reply_reason  = s_tdata[58:51];

	sort_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.flow     (flow),
		.item_s1  (item_s1)
	);

	sort_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_timeout (sort_pkg::ticks_t'(cfg_data)),
		.flow        (flow),
		.item_s1     (item_s1),
		.res         (res)
	);

	sort_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {3'b000, res_q.nak_reason, res_q.busy_res, res_q.call_tag,
	                  res_q.outcome, res_q.completed, res_q.accepted};

endmodule

`default_nettype wire
